### sv/kzbs_pkg.sv
// Package for the k-th zero binary search core: widths, codes and beat types.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package kzbs_pkg;

  localparam int unsigned PosWidth   = 20;
  localparam int unsigned BoundWidth = PosWidth + 1;

  typedef enum logic {
    OP_START    = 1'b0,
    OP_RESPONSE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_QUERY  = 1'b0,
    KIND_ANSWER = 1'b1
  } kind_e;

  typedef struct packed {
    op_e                 op;
    logic [PosWidth-1:0] rank;
    logic [PosWidth-1:0] ones_count;
  } in_beat_t;

  typedef struct packed {
    kind_e               kind;
    logic [PosWidth-1:0] position;
  } res_beat_t;

endpackage

`default_nettype wire

### sv/kzbs_in_stage.sv
// Input register of the k-th zero search: holds one accepted beat until the
// search stage consumes it. Depends on kzbs_pkg.
`default_nettype none

module kzbs_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kzbs_pkg::in_beat_t in_beat_i,
  input  wire logic              consume_i,
  output logic                   beat_valid_o,
  output kzbs_pkg::in_beat_t     beat_o
);

  logic               valid_q, valid_d;
  kzbs_pkg::in_beat_t beat_q;
  logic               load;

  // free, or emptied in this same cycle
  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

### sv/kzbs_search.sv
// Search state and single-pass step logic: bounds, rank, probe, found position.
// Also holds the array length register. Depends on kzbs_pkg.
`default_nettype none

module kzbs_search (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [kzbs_pkg::PosWidth-1:0]  cfg_wdata_i,
  input  wire logic                           step_i,
  input  wire kzbs_pkg::in_beat_t             beat_i,
  output logic                                res_valid_o,
  output kzbs_pkg::res_beat_t                 res_o
);

  localparam int unsigned PW = kzbs_pkg::PosWidth;
  localparam int unsigned BW = kzbs_pkg::BoundWidth;

  logic [PW-1:0] length_q;
  logic [BW-1:0] low_q, low_d, high_q, high_d;
  logic [PW-1:0] found_q, found_d, rank_q, rank_d, probe_q, probe_d;
  logic          searching_q, searching_d;

  logic [PW-1:0] zeros;
  logic [BW:0]   bound_sum;
  logic [BW-1:0] mid_ext;

  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    found_d     = found_q;
    rank_d      = rank_q;
    probe_d     = probe_q;
    searching_d = searching_q;
    res_valid_o = 1'b0;
    res_o.kind     = kzbs_pkg::KIND_QUERY;
    res_o.position = '0;
    mid_ext     = {1'b0, probe_q};
    // a count above the probe means no zeros in the prefix
    zeros = (beat_i.ones_count > probe_q) ? '0 : (probe_q - beat_i.ones_count);

    if (beat_i.op == kzbs_pkg::OP_START) begin
      rank_d      = beat_i.rank;
      low_d       = BW'(1);
      high_d      = {1'b0, length_q};
      found_d     = '0;
      searching_d = 1'b1;
      res_valid_o = 1'b1;
    end else if (searching_q) begin
      res_valid_o = 1'b1;
      if (zeros == rank_q) begin
        found_d = probe_q;
        high_d  = mid_ext - BW'(1);
      end else if (zeros < rank_q) begin
        low_d   = mid_ext + BW'(1);
      end else begin
        high_d  = mid_ext - BW'(1);
      end
    end

    bound_sum = {1'b0, low_d} + {1'b0, high_d};
    if (low_d <= high_d) begin
      probe_d        = bound_sum[PW:1];
      res_o.kind     = kzbs_pkg::KIND_QUERY;
      res_o.position = bound_sum[PW:1];
    end else begin
      searching_d    = 1'b0;
      res_o.kind     = kzbs_pkg::KIND_ANSWER;
      res_o.position = found_d;
    end
    if (!res_valid_o) begin
      // idle response: nothing moves
      probe_d     = probe_q;
      searching_d = searching_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= PW'(1);
      low_q       <= BW'(1);
      high_q      <= '0;
      found_q     <= '0;
      rank_q      <= '0;
      probe_q     <= '0;
      searching_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        length_q <= cfg_wdata_i;
      end
      if (step_i) begin
        low_q       <= low_d;
        high_q      <= high_d;
        found_q     <= found_d;
        rank_q      <= rank_d;
        probe_q     <= probe_d;
        searching_q <= searching_d;
      end
    end
  end

endmodule

`default_nettype wire

### sv/kzbs_out_buf.sv
// Result register plus one skid entry, so the search can step once more while a
// result beat waits downstream. Depends on kzbs_pkg.
`default_nettype none

module kzbs_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire kzbs_pkg::res_beat_t  push_beat_i,
  output logic                      can_push_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output kzbs_pkg::res_beat_t       out_beat_o
);

  logic                out_valid_q, skid_valid_q;
  kzbs_pkg::res_beat_t out_q, skid_q;
  logic                pop;

  assign pop        = out_valid_q && out_ready_i;
  assign can_push_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_beat_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_q <= push_beat_i;
      end else begin
        skid_q <= push_beat_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

### sv/kth_zero_binary_search_core.sv
// Top level of the k-th zero binary search core: input register, search step,
// result buffer. Depends on kzbs_pkg, kzbs_in_stage, kzbs_search, kzbs_out_buf.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------
//  in       | in  | in_valid_i / in_ready_o | op_i, rank_i, ones_count_i
//  out      | out | out_valid_o/out_ready_i | kind_o, position_o
//  cfg      | in  | cfg_we_i (no wait)      | cfg_wdata_i (array length)
//
// One beat per cycle while the result buffer has room. A beat lands in the
// input register; when the buffer has room, one add/shift/compare pass updates
// the bounds and produces the query or answer into the result buffer.
// Reset (rst_ni, async low) leaves the core idle with array length 1.
// The skid entry lets the search step once more while out is stalled; after
// that in_ready_o drops once a beat is held, until the consumer pops a beat.
`default_nettype none

module kth_zero_binary_search_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [kzbs_pkg::PosWidth-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           op_i,
  input  wire logic [kzbs_pkg::PosWidth-1:0]  rank_i,
  input  wire logic [kzbs_pkg::PosWidth-1:0]  ones_count_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                kind_o,
  output logic [kzbs_pkg::PosWidth-1:0]       position_o
);

  kzbs_pkg::in_beat_t  in_beat, step_beat;
  kzbs_pkg::res_beat_t res_beat, out_beat;
  logic                beat_valid, step, res_valid, can_push;

  assign in_beat.op         = kzbs_pkg::op_e'(op_i);
  assign in_beat.rank       = rank_i;
  assign in_beat.ones_count = ones_count_i;

  // a held beat steps only when the result buffer has room for its result
  assign step = beat_valid && can_push;

  kzbs_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat),
    .consume_i    (step),
    .beat_valid_o (beat_valid),
    .beat_o       (step_beat)
  );

  kzbs_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .beat_i      (step_beat),
    .res_valid_o (res_valid),
    .res_o       (res_beat)
  );

  kzbs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && res_valid),
    .push_beat_i (res_beat),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat)
  );

  assign kind_o     = out_beat.kind;
  assign position_o = out_beat.position;

endmodule

`default_nettype wire
